### hw/rtl/atf_pkg.sv
// Shared constants and the CORDIC angle table for the tilt angle filter.
`timescale 1ns / 1ps

package atf_pkg;

  localparam int ANGLE_ITERATIONS = 16;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int CORDIC_STEPS =
      (ANGLE_ITERATIONS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : ANGLE_ITERATIONS;
  localparam int SQRT_STEPS = 20;
  localparam int ROOT_W = 40;
  localparam int ANGLE_W = 24;
  localparam int OUT_W = 15;
  localparam int WEIGHT_W = 16;
  localparam int CNT_W = 5;

  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 24'sd5898240;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 16'd3932;
  localparam logic [ROOT_W-1:0] SQRT_FIRST_BIT = 40'h40_0000_0000;

  // atan(2^-i) in degrees, scaled by 65536 and rounded to nearest.
  function automatic logic signed [ANGLE_W-1:0] atan_entry(input logic [CNT_W-1:0] idx);
    logic signed [ANGLE_W-1:0] v;
    unique case (idx)
      5'd0:    v = 24'sd2949120;
      5'd1:    v = 24'sd1740967;
      5'd2:    v = 24'sd919879;
      5'd3:    v = 24'sd466945;
      5'd4:    v = 24'sd234379;
      5'd5:    v = 24'sd117304;
      5'd6:    v = 24'sd58666;
      5'd7:    v = 24'sd29335;
      5'd8:    v = 24'sd14668;
      5'd9:    v = 24'sd7334;
      5'd10:   v = 24'sd3667;
      5'd11:   v = 24'sd1833;
      5'd12:   v = 24'sd917;
      5'd13:   v = 24'sd458;
      5'd14:   v = 24'sd229;
      5'd15:   v = 24'sd115;
      5'd16:   v = 24'sd57;
      5'd17:   v = 24'sd29;
      5'd18:   v = 24'sd14;
      5'd19:   v = 24'sd7;
      5'd20:   v = 24'sd4;
      5'd21:   v = 24'sd2;
      5'd22:   v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/accel_tilt_angle_filter.sv
// Tilt angle filter top level: roll and pitch by square root and CORDIC, then low-pass.
// The block takes no new sample until the previous one is finished; the shared square
// root and CORDIC steps run one bit or one rotation per cycle, first for roll and then
// for pitch, and a zero root skips the CORDIC rotations.
// A new sample is accepted while the previous result waits in the output register.
// Reset (synchronous, active high) clears both filter states and sets the weight to 3932.
`timescale 1ns / 1ps

module accel_tilt_angle_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // roll_filtered, pitch_filtered, roll_raw, pitch_raw, zero pad
  input  logic        cfg_wen,
  input  logic [atf_pkg::WEIGHT_W-1:0] cfg_wdata
);
  import atf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQZ, S_SUMS, S_SQRT, S_CORDIC, S_STORE,
    S_FILT_R, S_FILT_P, S_UPD_P, S_EMIT
  } state_t;

  state_t state;

  logic [WEIGHT_W-1:0] filter_weight;
  logic signed [ANGLE_W-1:0] roll_state, pitch_state, roll_raw, pitch_raw;
  logic signed [15:0] ax, ay, az;
  logic [31:0] xx, yy, pitch_sum;
  logic [ROOT_W-1:0] rn, res, rbit;
  logic [CNT_W-1:0] cnt;
  logic pitch_sel;
  logic signed [ANGLE_W-1:0] cx, cy, ang;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] mul_p;
  logic [63:0] out_data;

  logic [ROOT_W-1:0] trial, rn_next, res_next;
  logic take;
  logic signed [ANGLE_W-1:0] dx, dy, ang_sat;
  logic signed [16:0] neg_x;
  logic signed [ANGLE_W-1:0] cy_init, special_ang;
  logic signed [24:0] d_roll, d_pitch;

  function automatic logic signed [ANGLE_W-1:0] filt_next(
      input logic signed [ANGLE_W-1:0] f, input logic signed [41:0] p);
    logic signed [41:0] inc;
    logic signed [26:0] sum;
    logic signed [ANGLE_W-1:0] r;
    inc = (p + 42'sd32768) >>> 16;
    sum = {{3{f[ANGLE_W-1]}}, f} + inc[26:0];
    if (sum > $signed({{3{1'b0}}, ANGLE_LIMIT})) begin
      r = ANGLE_LIMIT;
    end else if (sum < -$signed({{3{1'b0}}, ANGLE_LIMIT})) begin
      r = -ANGLE_LIMIT;
    end else begin
      r = sum[ANGLE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic signed [ANGLE_W-1:0] v);
    logic signed [ANGLE_W:0] s;
    s = ({v[ANGLE_W-1], v} + 25'sd256) >>> 9;
    return s[OUT_W-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = out_data;

  always_comb begin
    trial    = res + rbit;
    take     = (rn >= trial);
    rn_next  = take ? (rn - trial) : rn;
    res_next = take ? ((res >> 1) + rbit) : (res >> 1);
  end

  always_comb begin
    dx = cy >>> cnt;
    dy = cx >>> cnt;
    if (ang > ANGLE_LIMIT) begin
      ang_sat = ANGLE_LIMIT;
    end else if (ang < -ANGLE_LIMIT) begin
      ang_sat = -ANGLE_LIMIT;
    end else begin
      ang_sat = ang;
    end
  end

  always_comb begin
    neg_x = -{ax[15], ax};
    if (pitch_sel) begin
      cy_init = {{3{neg_x[16]}}, neg_x, 4'b0000};
    end else begin
      cy_init = {{4{ay[15]}}, ay, 4'b0000};
    end
    if (cy_init > 0) begin
      special_ang = ANGLE_LIMIT;
    end else if (cy_init < 0) begin
      special_ang = -ANGLE_LIMIT;
    end else begin
      special_ang = '0;
    end
    d_roll  = {roll_raw[ANGLE_W-1], roll_raw} - {roll_state[ANGLE_W-1], roll_state};
    d_pitch = {pitch_raw[ANGLE_W-1], pitch_raw} - {pitch_state[ANGLE_W-1], pitch_state};
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX: begin
        mul_a = {{9{ax[15]}}, ax};
        mul_b = {ax[15], ax};
      end
      S_SQY: begin
        mul_a = {{9{ay[15]}}, ay};
        mul_b = {ay[15], ay};
      end
      S_SQZ: begin
        mul_a = {{9{az[15]}}, az};
        mul_b = {az[15], az};
      end
      S_FILT_R: begin
        mul_a = d_roll;
        mul_b = $signed({1'b0, filter_weight});
      end
      S_FILT_P: begin
        mul_a = d_pitch;
        mul_b = $signed({1'b0, filter_weight});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      filter_weight <= WEIGHT_RESET;
      roll_state    <= '0;
      pitch_state   <= '0;
    end else begin
      if (cfg_wen) begin
        filter_weight <= cfg_wdata;
      end
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ax    <= s_tdata[15:0];
            ay    <= s_tdata[31:16];
            az    <= s_tdata[47:32];
            state <= S_SQX;
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          xx    <= mul_p[31:0];
          state <= S_SQZ;
        end
        S_SQZ: begin
          yy    <= mul_p[31:0];
          state <= S_SUMS;
        end
        S_SUMS: begin
          rn        <= {xx + mul_p[31:0], 8'h00};
          pitch_sum <= yy + mul_p[31:0];
          res       <= '0;
          rbit      <= SQRT_FIRST_BIT;
          cnt       <= '0;
          pitch_sel <= 1'b0;
          state     <= S_SQRT;
        end
        S_SQRT: begin
          rn   <= rn_next;
          res  <= res_next;
          rbit <= rbit >> 2;
          if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
            cnt <= '0;
            cx  <= res_next[ANGLE_W-1:0];
            cy  <= cy_init;
            if (res_next == '0) begin
              ang   <= special_ang;
              state <= S_STORE;
            end else begin
              ang   <= '0;
              state <= S_CORDIC;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_CORDIC: begin
          if (!cy[ANGLE_W-1]) begin
            cx  <= cx + dx;
            cy  <= cy - dy;
            ang <= ang + atan_entry(cnt);
          end else begin
            cx  <= cx - dx;
            cy  <= cy + dy;
            ang <= ang - atan_entry(cnt);
          end
          cnt <= cnt + 5'd1;
          if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          if (!pitch_sel) begin
            roll_raw  <= ang_sat;
            rn        <= {pitch_sum, 8'h00};
            res       <= '0;
            rbit      <= SQRT_FIRST_BIT;
            cnt       <= '0;
            pitch_sel <= 1'b1;
            state     <= S_SQRT;
          end else begin
            pitch_raw <= ang_sat;
            state     <= S_FILT_R;
          end
        end
        S_FILT_R: state <= S_FILT_P;
        S_FILT_P: begin
          roll_state <= filt_next(roll_state, mul_p);
          state      <= S_UPD_P;
        end
        S_UPD_P: begin
          pitch_state <= filt_next(pitch_state, mul_p);
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            out_data <= {4'b0000, to_out(pitch_raw), to_out(roll_raw),
                         to_out(pitch_state), to_out(roll_state)};
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_state_limit: assert property (@(posedge clk) disable iff (rst)
      (roll_state <= ANGLE_LIMIT) && (roll_state >= -ANGLE_LIMIT) &&
      (pitch_state <= ANGLE_LIMIT) && (pitch_state >= -ANGLE_LIMIT))
    else $error("Filter state is outside the angle limit.");

  a_sqrt_bit: assert property (@(posedge clk) disable iff (rst)
      (state == S_SQRT) |-> $onehot(rbit))
    else $error("Square root trial bit is not one-hot.");

  a_cordic_x_pos: assert property (@(posedge clk) disable iff (rst)
      (state == S_CORDIC) |-> (cx > 0))
    else $error("CORDIC x component is not positive.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
      (s_tvalid && s_tready) |=> !s_tready)
    else $error("Block accepted a transaction while busy.");

endmodule

### bench/tb.sv
// Self-checking testbench for the accelerometer tilt angle filter.
`timescale 1ns / 1ps

module tb;

  import atf_pkg::*;

  localparam longint ANGLE_MAX = 5898240;
  localparam longint OUT_MAX = 11520;
  localparam int RANDOM_PER_PHASE = 305;
  localparam int NUM_PHASES = 6;
  localparam int DIR_COUNT = 22;

  localparam longint ATAN_Q16 [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  localparam int PH_SND_IDLE [NUM_PHASES] = '{0, 60, 0, 6, 0, 60};
  localparam int PH_RCV_STALL [NUM_PHASES] = '{0, 0, 60, 6, 0, 0};

  // Layout of m_tdata, lowest field last in the list.
  typedef struct packed {
    logic [3:0] pad;
    logic signed [OUT_W-1:0] pitch_raw;
    logic signed [OUT_W-1:0] roll_raw;
    logic signed [OUT_W-1:0] pitch_filt;
    logic signed [OUT_W-1:0] roll_filt;
  } tilt_result_t;

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
    logic zero_result;
  } sample_row_t;

  localparam sample_row_t DIR_ROWS [DIR_COUNT] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{16'sd0, 16'sd0, 16'sd0, 1'b1},
    '{16'sd0, 16'sd0, 16'sh7fff, 1'b0},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0},
    '{16'sd0, 16'sh7fff, 16'sd0, 1'b0},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b0},
    '{16'sh7fff, 16'sd0, 16'sd0, 1'b0},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b0},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0},
    '{16'sh8000, 16'sh7fff, 16'sh8000, 1'b0},
    '{16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0},
    '{16'sd0, 16'sd5, 16'sd0, 1'b0},
    '{16'sd0, -16'sd5, 16'sd0, 1'b0},
    '{16'sd0, 16'sd0, 16'sd7, 1'b0},
    '{16'sd0, 16'sd0, -16'sd7, 1'b0},
    '{16'sd1, 16'sd1, 16'sd1, 1'b0},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0},
    '{16'sd1, 16'sd0, 16'sd0, 1'b0},
    '{-16'sd1, 16'sd0, 16'sd0, 1'b0},
    '{16'sd256, 16'sd256, 16'sd0, 1'b0},
    '{16'sd181, 16'sd0, 16'sd181, 1'b0}
  };

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [47:0] s_tdata;   // accel_x, accel_y, accel_z
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;   // roll_filtered, pitch_filtered, roll_raw, pitch_raw, zero pad
  logic cfg_wen;
  logic [WEIGHT_W-1:0] cfg_wdata;

  logic [WEIGHT_W-1:0] weight_model;
  longint roll_lp;
  longint pitch_lp;
  tilt_result_t expected_tilt_q [$];
  tilt_result_t got_tilt;
  tilt_result_t want_tilt;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int weight_settings = 1;

  accel_tilt_angle_filter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint tilt_angle_q16(input longint num, input longint p, input longint q);
    longint cx;
    longint cy;
    longint ang;
    longint dx;
    longint dy;
    cx = int_sqrt(longint'((p * p + q * q) << 8));
    cy = num * 16;
    ang = 0;
    if (cx == 0) begin
      if (cy > 0) return ANGLE_MAX;
      if (cy < 0) return -ANGLE_MAX;
      return 0;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        ang += ATAN_Q16[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        ang -= ATAN_Q16[i];
      end
    end
    return clamp_sym(ang, ANGLE_MAX);
  endfunction

  function automatic longint low_pass(input longint f, input longint a);
    longint w;
    w = weight_model;
    return clamp_sym(f + (((a - f) * w + 32768) >>> 16), ANGLE_MAX);
  endfunction

  function automatic logic signed [OUT_W-1:0] to_degree_128(input longint v);
    longint r;
    r = clamp_sym((v + 256) >>> 9, OUT_MAX);
    return r[OUT_W-1:0];
  endfunction

  function automatic tilt_result_t predict_tilt(input logic [47:0] d);
    longint ax;
    longint ay;
    longint az;
    longint roll;
    longint pitch;
    tilt_result_t r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    roll = tilt_angle_q16(ay, ax, az);
    pitch = tilt_angle_q16(-ax, ay, az);
    roll_lp = low_pass(roll_lp, roll);
    pitch_lp = low_pass(pitch_lp, pitch);
    r.pad = '0;
    r.roll_filt = to_degree_128(roll_lp);
    r.pitch_filt = to_degree_128(pitch_lp);
    r.roll_raw = to_degree_128(roll);
    r.pitch_raw = to_degree_128(pitch);
    return r;
  endfunction

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return 16'h0001;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] near(input int span);
    int v;
    v = int'($urandom_range(0, 2 * span)) - span;
    return v[15:0];
  endfunction

  function automatic logic [47:0] random_sample();
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    x = 16'($urandom);
    y = 16'($urandom);
    z = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2: ;
      3, 4, 5: begin
        x = near(300);
        y = near(300);
        z = near(300);
      end
      6: begin
        case ($urandom_range(0, 2))
          0: begin x = '0; z = '0; end
          1: begin y = '0; z = '0; end
          default: begin x = '0; y = '0; z = '0; end
        endcase
      end
      7: begin
        x = edge_value();
        y = edge_value();
        z = edge_value();
      end
      default: begin
        x = near(8);
        y = near(8);
        z = near(8);
      end
    endcase
    return {z, y, x};
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
             results_seen, field, got, want);
    mismatches++;
  endtask

  task automatic send_sample(input logic [47:0] d, input bit zero_result);
    tilt_result_t pred;
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
    pred = predict_tilt(d);
    expected_tilt_q.push_back(zero_result ? tilt_result_t'('0) : pred);
    samples_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_tilt_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_weight(input logic [WEIGHT_W-1:0] w);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= w;
    weight_model = w;
    weight_settings++;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      got_tilt = tilt_result_t'(m_tdata);
      if (expected_tilt_q.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want_tilt = expected_tilt_q.pop_front();
        if (got_tilt.roll_filt !== want_tilt.roll_filt)
          report_mismatch("roll_filtered", int'(got_tilt.roll_filt), int'(want_tilt.roll_filt));
        if (got_tilt.pitch_filt !== want_tilt.pitch_filt)
          report_mismatch("pitch_filtered", int'(got_tilt.pitch_filt),
                          int'(want_tilt.pitch_filt));
        if (got_tilt.roll_raw !== want_tilt.roll_raw)
          report_mismatch("roll_raw", int'(got_tilt.roll_raw), int'(want_tilt.roll_raw));
        if (got_tilt.pitch_raw !== want_tilt.pitch_raw)
          report_mismatch("pitch_raw", int'(got_tilt.pitch_raw), int'(want_tilt.pitch_raw));
        if (got_tilt.pad !== 4'd0)
          report_mismatch("pad", int'(got_tilt.pad), 0);
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    weight_model = WEIGHT_RESET;
    roll_lp = 0;
    pitch_lp = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_results();
        case (ph)
          1: write_weight(16'd0);
          2: write_weight(16'hffff);
          3: write_weight(16'($urandom_range(0, 65535)));
          4: write_weight(16'd1);
          default: write_weight(16'h8000);
        endcase
      end
      snd_idle_pct = PH_SND_IDLE[ph];
      rcv_stall_pct = PH_RCV_STALL[ph];
      if (ph == 0) begin
        for (int r = 0; r < DIR_COUNT; r++)
          send_sample({DIR_ROWS[r].z, DIR_ROWS[r].y, DIR_ROWS[r].x}, DIR_ROWS[r].zero_result);
      end
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (ph == 2 && i == RANDOM_PER_PHASE / 2) drain_results();
        send_sample(random_sample(), 1'b0);
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("Sent %0d accelerometer samples over %0d weight settings and four idle patterns.",
             samples_sent, weight_settings);
    $display("Compared %0d tilt results against the predicted angles.", results_seen);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Timeout with %0d results still pending.", expected_tilt_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/atf_pkg.sv
hw/rtl/accel_tilt_angle_filter.sv
bench/tb.sv
